@@ sv/nfba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfba_pkg: shared definitions for the next-fit block run allocator
// Request and status codes, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
package nfba_pkg;

  // Default number of map entries.
  localparam int unsigned MapBlocksDefault = 1024;

  // Field widths fixed by the interface.
  localparam int unsigned CfgW   = 11;
  localparam int unsigned LenW   = 11;
  localparam int unsigned BlockW = 10;

  // Reset value of the managed block count register.
  localparam logic [CfgW-1:0] BlocksInUseReset = 11'd1024;

  // Request codes.
  localparam logic ReqAlloc = 1'b0;
  localparam logic ReqFree  = 1'b1;

  // Status codes.
  localparam logic StatusOk      = 1'b0;
  localparam logic StatusNoSpace = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_DISPATCH,
    ST_A_RD,
    ST_A_EVAL,
    ST_A_MARK,
    ST_F_TOP_RD,
    ST_F_TOP_EVAL,
    ST_F_WR,
    ST_F_MRG_RD,
    ST_F_MRG_EVAL,
    ST_R_RD,
    ST_R_EVAL,
    ST_DONE
  } state_e;

endpackage

@@ sv/next_fit_block_run_allocator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_fit_block_run_allocator_core: next-fit allocator of contiguous runs
// Keeps a map of per-block free run counts and serves allocate and free
// requests with a sequencer around one map memory and a probe add/compare unit.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                Payload
// --------  ---------  -----------------------  -------------------------------
// request   in         start & !busy            req_type_i, run_length_i,
//                                               first_block_i, last_block_i
// result    out        done_o (one cycle pulse) status_o, granted_block_o
// config    in         cfg_we_i                 cfg_wdata_i (blocks_in_use)
//
// Sequence: every request passes through a dispatch and a result state. The
// first request after reset or after a config write first refills the map,
// one entry a cycle. An allocate reads, then evaluates, each probed map
// entry and then marks each granted block. A free reads the count just above
// the run (skipped when the run ends at the top of the managed area), writes
// each freed block, reads and evaluates each merged free block below until
// the end of the merge, and reads and evaluates each step the rover is pulled
// back until a final check. All of it is set by the single map memory port
// pair. busy stays high for the whole request; done_o pulses for one cycle
// and the receiver cannot stall it.
// Reset clears the sequencer, rover and map-ready flag; map contents are
// undefined until the refill sweep.
// ----------------------------------------------------------------------------
module next_fit_block_run_allocator_core #(
  parameter int unsigned MapBlocks = nfba_pkg::MapBlocksDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request
  input  logic                         start,
  output logic                         busy,
  input  logic                         req_type_i,
  input  logic [nfba_pkg::LenW-1:0]    run_length_i,
  input  logic [nfba_pkg::BlockW-1:0]  first_block_i,
  input  logic [nfba_pkg::BlockW-1:0]  last_block_i,
  // result
  output logic                         done_o,
  output logic                         status_o,
  output logic [nfba_pkg::BlockW-1:0]  granted_block_o,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [nfba_pkg::CfgW-1:0]    cfg_wdata_i
);

  localparam int unsigned IW = $clog2(MapBlocks);       // map index
  localparam int unsigned CW = $clog2(MapBlocks + 1);   // run count
  localparam int unsigned WW = (CW > nfba_pkg::LenW) ? CW : nfba_pkg::LenW;

  // Registers
  nfba_pkg::state_e             state_q, state_d;
  logic [nfba_pkg::CfgW-1:0]    biu_q;
  logic                         map_ready_q, map_ready_d;
  logic [IW-1:0]                rover_q, rover_d;
  logic [CW-1:0]                n_q, n_d;
  logic                         type_q;
  logic [nfba_pkg::LenW-1:0]    len_q;
  logic [nfba_pkg::BlockW-1:0]  first_q, last_q;
  logic [IW-1:0]                ptr_q, ptr_d;
  logic [CW-1:0]                trav_q, trav_d;
  logic [CW-1:0]                j_q, j_d;
  logic                         status_q, status_d;
  logic [nfba_pkg::BlockW-1:0]  granted_q, granted_d;

  // Map memory ports
  logic           map_we;
  logic [IW-1:0]  map_waddr;
  logic [CW-1:0]  map_wdata;
  logic [IW-1:0]  map_raddr;
  logic [CW-1:0]  map_rd;

  nfba_map_ram #(
    .MapBlocks (MapBlocks)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rd)
  );

  // Managed block count: zero acts as one, clamp at the map size.
  logic [CW-1:0] n_clamped;
  always_comb begin
    if (biu_q == '0) begin
      n_clamped = CW'(1);
    end else if (32'(biu_q) > 32'(MapBlocks)) begin
      n_clamped = CW'(MapBlocks);
    end else begin
      n_clamped = CW'(biu_q);
    end
  end

  // Add/compare unit of the allocate walk: one probe of the next-fit walk.
  logic [CW-1:0] rem;        // blocks from ptr to end of managed area
  logic [CW-1:0] step;
  logic          a_fit;
  logic          a_wrap;
  logic [CW-1:0] trav_nxt;
  logic [IW-1:0] ptr_nxt;
  logic          a_exhausted;
  logic [WW-1:0] fit_end;
  always_comb begin
    rem         = n_q - CW'(ptr_q);
    step        = (map_rd == '0) ? CW'(1) : map_rd;
    a_fit       = (map_rd != '0) && (WW'(len_q) <= WW'(map_rd));
    a_wrap      = (step >= rem);
    trav_nxt    = a_wrap ? (trav_q + rem) : (trav_q + step);
    ptr_nxt     = a_wrap ? '0 : (ptr_q + IW'(step));
    a_exhausted = (trav_nxt >= n_q);
    fit_end     = WW'(ptr_q) + WW'(len_q);
  end

  // Other decode terms
  logic fill_last, len_zero, free_bad, top_edge, wr_last, ptr_zero, rover_zero;
  logic rover_out;
  assign fill_last  = (ptr_q == IW'(n_q - CW'(1)));
  assign len_zero   = (len_q == '0);
  assign free_bad   = (first_q > last_q) || (WW'(last_q) >= WW'(n_q));
  assign top_edge   = ((WW'(last_q) + WW'(1)) >= WW'(n_q));
  assign wr_last    = (ptr_q == IW'(first_q));
  assign ptr_zero   = (ptr_q == '0);
  assign rover_zero = (rover_q == '0);
  assign rover_out  = (CW'(rover_q) >= n_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nfba_pkg::ST_IDLE: begin
        if (start) begin
          state_d = map_ready_q ? nfba_pkg::ST_DISPATCH : nfba_pkg::ST_FILL;
        end
      end
      nfba_pkg::ST_FILL: begin
        if (fill_last) begin
          state_d = nfba_pkg::ST_DISPATCH;
        end
      end
      nfba_pkg::ST_DISPATCH: begin
        if (type_q == nfba_pkg::ReqAlloc) begin
          state_d = len_zero ? nfba_pkg::ST_DONE : nfba_pkg::ST_A_RD;
        end else if (free_bad) begin
          state_d = nfba_pkg::ST_DONE;
        end else begin
          state_d = top_edge ? nfba_pkg::ST_F_WR : nfba_pkg::ST_F_TOP_RD;
        end
      end
      nfba_pkg::ST_A_RD:       state_d = nfba_pkg::ST_A_EVAL;
      nfba_pkg::ST_A_EVAL: begin
        if (a_fit) begin
          state_d = nfba_pkg::ST_A_MARK;
        end else if (a_exhausted) begin
          state_d = nfba_pkg::ST_DONE;
        end else begin
          state_d = nfba_pkg::ST_A_RD;
        end
      end
      nfba_pkg::ST_A_MARK: begin
        if (j_q == CW'(1)) begin
          state_d = nfba_pkg::ST_DONE;
        end
      end
      nfba_pkg::ST_F_TOP_RD:   state_d = nfba_pkg::ST_F_TOP_EVAL;
      nfba_pkg::ST_F_TOP_EVAL: state_d = nfba_pkg::ST_F_WR;
      nfba_pkg::ST_F_WR: begin
        if (wr_last) begin
          state_d = nfba_pkg::ST_F_MRG_RD;
        end
      end
      nfba_pkg::ST_F_MRG_RD: begin
        state_d = ptr_zero ? nfba_pkg::ST_R_RD : nfba_pkg::ST_F_MRG_EVAL;
      end
      nfba_pkg::ST_F_MRG_EVAL: begin
        state_d = (map_rd != '0) ? nfba_pkg::ST_F_MRG_RD : nfba_pkg::ST_R_RD;
      end
      nfba_pkg::ST_R_RD: begin
        state_d = rover_zero ? nfba_pkg::ST_DONE : nfba_pkg::ST_R_EVAL;
      end
      nfba_pkg::ST_R_EVAL: begin
        state_d = (map_rd != '0) ? nfba_pkg::ST_R_RD : nfba_pkg::ST_DONE;
      end
      nfba_pkg::ST_DONE:       state_d = nfba_pkg::ST_IDLE;
      default:                 state_d = nfba_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    map_ready_d = map_ready_q;
    rover_d     = rover_q;
    n_d         = n_q;
    ptr_d       = ptr_q;
    trav_d      = trav_q;
    j_d         = j_q;
    status_d    = status_q;
    granted_d   = granted_q;
    map_we      = 1'b0;
    map_waddr   = ptr_q;
    map_wdata   = '0;
    map_raddr   = ptr_q;
    case (state_q)
      nfba_pkg::ST_IDLE: begin
        n_d   = n_clamped;
        ptr_d = '0;
      end
      nfba_pkg::ST_FILL: begin
        // Mark every managed block free with its distance to the end.
        map_we    = 1'b1;
        map_wdata = n_q - CW'(ptr_q);
        ptr_d     = ptr_q + IW'(1);
        if (fill_last) begin
          map_ready_d = 1'b1;
          rover_d     = '0;
        end
      end
      nfba_pkg::ST_DISPATCH: begin
        status_d  = nfba_pkg::StatusOk;
        granted_d = '0;
        trav_d    = '0;
        if (type_q == nfba_pkg::ReqAlloc) begin
          if (len_zero) begin
            status_d = nfba_pkg::StatusNoSpace;
          end
          ptr_d = rover_out ? '0 : rover_q;
        end else if (!free_bad) begin
          if (rover_out) begin
            rover_d = '0;
          end
          ptr_d = IW'(last_q);
          j_d   = CW'(1);
        end
      end
      nfba_pkg::ST_A_RD: begin
        map_raddr = ptr_q;
      end
      nfba_pkg::ST_A_EVAL: begin
        if (a_fit) begin
          granted_d = nfba_pkg::BlockW'(ptr_q);
          rover_d   = (fit_end >= WW'(n_q)) ? '0 : IW'(fit_end);
          j_d       = CW'(len_q);
        end else begin
          trav_d = trav_nxt;
          ptr_d  = ptr_nxt;
          if (a_exhausted) begin
            status_d = nfba_pkg::StatusNoSpace;
          end
        end
      end
      nfba_pkg::ST_A_MARK: begin
        // Clear the granted run, one block a cycle.
        map_we    = 1'b1;
        map_wdata = '0;
        ptr_d     = ptr_q + IW'(1);
        j_d       = j_q - CW'(1);
      end
      nfba_pkg::ST_F_TOP_RD: begin
        map_raddr = IW'(WW'(last_q) + WW'(1));
      end
      nfba_pkg::ST_F_TOP_EVAL: begin
        j_d = map_rd + CW'(1);
      end
      nfba_pkg::ST_F_WR: begin
        // Rebuild counts downward from the top of the freed run.
        map_we    = 1'b1;
        map_wdata = j_q;
        j_d       = j_q + CW'(1);
        if (!wr_last) begin
          ptr_d = ptr_q - IW'(1);
        end
      end
      nfba_pkg::ST_F_MRG_RD: begin
        map_raddr = ptr_q - IW'(1);
      end
      nfba_pkg::ST_F_MRG_EVAL: begin
        // Merge a free block below into the run.
        if (map_rd != '0) begin
          map_we    = 1'b1;
          map_waddr = ptr_q - IW'(1);
          map_wdata = j_q;
          j_d       = j_q + CW'(1);
          ptr_d     = ptr_q - IW'(1);
        end
      end
      nfba_pkg::ST_R_RD: begin
        map_raddr = rover_q - IW'(1);
      end
      nfba_pkg::ST_R_EVAL: begin
        // Pull the rover back over free blocks just below it.
        if (map_rd != '0) begin
          rover_d = rover_q - IW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nfba_pkg::ST_IDLE;
      biu_q       <= nfba_pkg::BlocksInUseReset;
      map_ready_q <= 1'b0;
      rover_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        // A new map size drops the map; refill on the next request.
        biu_q       <= cfg_wdata_i;
        map_ready_q <= 1'b0;
        rover_q     <= '0;
      end else begin
        map_ready_q <= map_ready_d;
        rover_q     <= rover_d;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    if (state_q == nfba_pkg::ST_IDLE && start) begin
      type_q  <= req_type_i;
      len_q   <= run_length_i;
      first_q <= first_block_i;
      last_q  <= last_block_i;
    end
    n_q       <= n_d;
    ptr_q     <= ptr_d;
    trav_q    <= trav_d;
    j_q       <= j_d;
    status_q  <= status_d;
    granted_q <= granted_d;
  end

  // Outputs
  always_comb begin
    busy            = (state_q != nfba_pkg::ST_IDLE);
    done_o          = (state_q == nfba_pkg::ST_DONE);
    status_o        = status_q;
    granted_block_o = granted_q;
  end

endmodule

@@ sv/nfba_map_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfba_map_ram: block map storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module nfba_map_ram #(
  parameter int unsigned MapBlocks = nfba_pkg::MapBlocksDefault
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [$clog2(MapBlocks)-1:0]       waddr_i,
  input  logic [$clog2(MapBlocks+1)-1:0]     wdata_i,
  input  logic [$clog2(MapBlocks)-1:0]       raddr_i,
  output logic [$clog2(MapBlocks+1)-1:0]     rdata_o
);

  localparam int unsigned DataW = $clog2(MapBlocks + 1);

  logic [DataW-1:0] mem_q [MapBlocks];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sv/nfba_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfba_checker: port-level checks for the block run allocator
// Watches the request and result ports; bound to the top level below.
// ----------------------------------------------------------------------------
module nfba_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         done_o,
  input logic                         status_o,
  input logic [nfba_pkg::BlockW-1:0]  granted_block_o
);

  // An accepted request raises busy.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request transfer did not raise busy");

  // A result only appears for a request in flight.
  a_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe without a request in flight");

  // A result strobe is followed by idle, with no second strobe.
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy))
    else $error("result strobe not followed by idle");

  // A refused allocate grants nothing.
  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == nfba_pkg::StatusNoSpace) |-> (granted_block_o == '0))
    else $error("out-of-space result with nonzero granted block");

endmodule

bind next_fit_block_run_allocator_core nfba_checker u_nfba_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .status_o        (status_o),
  .granted_block_o (granted_block_o)
);
